/* rtl/core/mfde_pkg.sv */
// Package for the monochrome framebuffer draw engine.
// Holds geometry constants, command codes, controller states, the control structs
// and the font table. It depends on nothing.
package mfde_pkg;

   localparam int NATIVE_WIDTH  = 128;
   localparam int NATIVE_HEIGHT = 32;
   localparam int STORE_SIZE    = NATIVE_WIDTH * NATIVE_HEIGHT / 8;
   localparam int ADDR_W        = $clog2(STORE_SIZE);
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int DIGIT_STEP    = 6;
   localparam int NUM_DIGITS    = 5;
   localparam int BCD_STEPS     = 16;

   typedef enum logic [2:0] {
      MODE_CLEAR   = 3'd0,
      MODE_PIXEL   = 3'd1,
      MODE_FILL    = 3'd2,
      MODE_OUTLINE = 3'd3,
      MODE_CHAR    = 3'd4,
      MODE_NUMBER  = 3'd5,
      MODE_READ    = 3'd6,
      MODE_NONE    = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BCD,
      ST_DIGIT,
      ST_SCAN,
      ST_WRITE,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic bcd_step;
      logic num_start;
      logic scan_rd;
      logic advance;
      logic plot_write;
      logic read_issue;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bcd_last;
      logic walk_done;
      logic hit;
      logic out_free;
   } status_type;

   // Five columns packed as {col4, col3, col2, col1, col0}; bit 0 of a column is the top row.
   function automatic logic [39:0] glyph_bits(input logic [7:0] code_in);
      logic [7:0] code;
      logic [39:0] g;
      code = code_in;
      if (code >= 8'h61 && code <= 8'h7A) begin
         code = 8'(code - 8'h20);
      end
      unique case (code)
         8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
         8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
         8'h47: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
         8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         8'h4A: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
         8'h4B: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
         8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
         8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
         8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
         8'h51: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
         8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
         8'h53: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
         8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
         8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         8'h5A: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
         8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         8'h2E: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         8'h3A: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

/* rtl/core/mfde_ctrl.sv */
// Controller state machine of the framebuffer draw engine.
// Sequences clear sweeps, number conversion, pixel walks, reads and the response.
// Depends on mfde_pkg.
module mfde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_mode,
   output logic                  req_stall,
   input  mfde_pkg::status_type  status,
   output mfde_pkg::cmd_type     cmd
);

   mfde_pkg::state_type state_ff, state_in;
   logic pend_ff, pend_in;
   logic accept;

   assign req_stall = (state_ff != mfde_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfde_pkg::ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         mfde_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = pend_ff ? mfde_pkg::ST_RESP : mfde_pkg::ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         mfde_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (mfde_pkg::mode_type'(req_mode))
                  mfde_pkg::MODE_CLEAR: begin
                     state_in = mfde_pkg::ST_CLEAR;
                     pend_in  = 1'b1;
                  end
                  mfde_pkg::MODE_NUMBER: state_in = mfde_pkg::ST_BCD;
                  mfde_pkg::MODE_READ:   state_in = mfde_pkg::ST_READ;
                  mfde_pkg::MODE_NONE:   state_in = mfde_pkg::ST_RESP;
                  default:               state_in = mfde_pkg::ST_SCAN;
               endcase
            end
         end
         mfde_pkg::ST_BCD: begin
            if (status.bcd_last) begin
               state_in = mfde_pkg::ST_DIGIT;
            end
         end
         mfde_pkg::ST_DIGIT: state_in = mfde_pkg::ST_SCAN;
         mfde_pkg::ST_SCAN: begin
            if (status.walk_done) begin
               state_in = mfde_pkg::ST_RESP;
            end else if (status.hit) begin
               state_in = mfde_pkg::ST_WRITE;
            end
         end
         mfde_pkg::ST_WRITE: state_in = mfde_pkg::ST_SCAN;
         mfde_pkg::ST_READ:  state_in = mfde_pkg::ST_RESP;
         mfde_pkg::ST_RESP: begin
            if (status.out_free) begin
               state_in = mfde_pkg::ST_IDLE;
            end
         end
         default: state_in = mfde_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mfde_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         mfde_pkg::ST_IDLE:  cmd.load       = accept;
         mfde_pkg::ST_BCD:   cmd.bcd_step   = 1'b1;
         mfde_pkg::ST_DIGIT: cmd.num_start  = 1'b1;
         mfde_pkg::ST_SCAN: begin
            if (!status.walk_done) begin
               cmd.scan_rd = status.hit;
               cmd.advance = !status.hit;
            end
         end
         mfde_pkg::ST_WRITE: begin
            cmd.plot_write = 1'b1;
            cmd.advance    = 1'b1;
         end
         mfde_pkg::ST_READ:  cmd.read_issue = 1'b1;
         mfde_pkg::ST_RESP:  cmd.resp_load  = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* rtl/core/mfde_datapath.sv */
// Datapath of the framebuffer draw engine: command registers, pixel walker,
// decimal converter, frame store memory and the response register. Depends on mfde_pkg.
module mfde_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mfde_pkg::cmd_type     cmd,
   output mfde_pkg::status_type  status,
   input  logic [2:0]            req_mode,
   input  logic [7:0]            req_x_pos,
   input  logic [7:0]            req_y_pos,
   input  logic [7:0]            req_rect_width,
   input  logic [7:0]            req_rect_height,
   input  logic [7:0]            req_char_code,
   input  logic [15:0]           req_number_value,
   input  logic                  req_pixel_on,
   input  logic [8:0]            req_read_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_read_data
);

   localparam int AW = mfde_pkg::ADDR_W;

   logic [7:0] mem [mfde_pkg::STORE_SIZE];
   logic [7:0] rd_data_ff;

   mfde_pkg::mode_type mode_ff;
   logic [7:0] x_ff, y_ff, w_ff, h_ff, code_ff, xb_ff, xb_in;
   logic on_ff, rd_ok_ff;
   logic [AW-1:0] ridx_ff;
   logic [7:0] a_ff, a_in, b_ff, b_in;
   logic [1:0] seg_ff, seg_in;
   logic [2:0] dig_ff, dig_in, dig_top;
   logic done_ff, done_in;
   logic [19:0] bcd_ff, bcd_adj;
   logic [15:0] bin_ff;
   logic [3:0] bcd_cnt_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] hit_addr_ff;
   logic [7:0] hit_mask_ff;
   logic hit_on_ff;
   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic [7:0] px, py, lim, row, glyph_code, gcol;
   logic [39:0] gbits;
   logic inb, val, glyph_end;
   logic [AW-1:0] pix_addr, rd_addr, wr_addr;
   logic [7:0] wr_data;
   logic wr_en, rd_en;

   // Current walk position for each drawing mode.
   always_comb begin
      glyph_code = (mode_ff == mfde_pkg::MODE_NUMBER)
                   ? 8'(8'h30 + 8'(4'(bcd_ff >> {dig_ff, 2'b00})))
                   : code_ff;
      gbits = mfde_pkg::glyph_bits(glyph_code);
      gcol  = 8'(gbits >> {a_ff[2:0], 3'b000});
      lim   = (seg_ff[1]) ? h_ff : w_ff;
      px    = x_ff;
      py    = y_ff;
      inb   = 1'b0;
      val   = on_ff;
      unique case (mode_ff)
         mfde_pkg::MODE_PIXEL: inb = 1'b1;
         mfde_pkg::MODE_FILL: begin
            px  = 8'(x_ff + a_ff);
            py  = 8'(y_ff + b_ff);
            inb = (a_ff < w_ff) && (b_ff < h_ff);
         end
         mfde_pkg::MODE_OUTLINE: begin
            val = 1'b1;
            inb = (a_ff < lim);
            unique case (seg_ff)
               2'd0: px = 8'(x_ff + a_ff);
               2'd1: begin
                  px = 8'(x_ff + a_ff);
                  py = 8'(y_ff + h_ff + 8'hFF);
               end
               2'd2: py = 8'(y_ff + a_ff);
               default: begin
                  px = 8'(x_ff + w_ff + 8'hFF);
                  py = 8'(y_ff + a_ff);
               end
            endcase
         end
         mfde_pkg::MODE_CHAR: begin
            px  = 8'(x_ff + a_ff);
            py  = 8'(y_ff + b_ff);
            inb = gcol[b_ff[2:0]];
         end
         mfde_pkg::MODE_NUMBER: begin
            px  = 8'(xb_ff + a_ff);
            py  = 8'(y_ff + b_ff);
            inb = gcol[b_ff[2:0]];
         end
         default: inb = 1'b0;
      endcase
      row      = 8'(8'(mfde_pkg::NATIVE_HEIGHT - 1) - px);
      pix_addr = AW'(int'(row[7:3]) * mfde_pkg::NATIVE_WIDTH + int'(py));
   end

   assign status.hit = !done_ff && inb && (px < 8'(mfde_pkg::NATIVE_HEIGHT))
                       && ({1'b0, py} < 9'(mfde_pkg::NATIVE_WIDTH));
   assign status.walk_done  = done_ff;
   assign status.clear_last = (clr_ff == AW'(mfde_pkg::STORE_SIZE - 1));
   assign status.bcd_last   = (bcd_cnt_ff == 4'(mfde_pkg::BCD_STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Next walk position.
   always_comb begin
      a_in      = 8'(a_ff + 8'd1);
      b_in      = b_ff;
      seg_in    = seg_ff;
      dig_in    = dig_ff;
      xb_in     = xb_ff;
      done_in   = done_ff;
      glyph_end = 1'b0;
      unique case (mode_ff)
         mfde_pkg::MODE_FILL: begin
            if (w_ff == 8'd0 || a_ff == 8'(w_ff - 8'd1)) begin
               a_in = '0;
               if (h_ff == 8'd0 || b_ff == 8'(h_ff - 8'd1)) begin
                  done_in = 1'b1;
               end else begin
                  b_in = 8'(b_ff + 8'd1);
               end
            end
         end
         mfde_pkg::MODE_OUTLINE: begin
            if (lim == 8'd0 || a_ff == 8'(lim - 8'd1)) begin
               a_in = '0;
               if (seg_ff == 2'd3) begin
                  done_in = 1'b1;
               end else begin
                  seg_in = 2'(seg_ff + 2'd1);
               end
            end
         end
         mfde_pkg::MODE_CHAR, mfde_pkg::MODE_NUMBER: begin
            if (a_ff == 8'(mfde_pkg::GLYPH_COLS - 1)) begin
               a_in = '0;
               if (b_ff == 8'(mfde_pkg::GLYPH_ROWS - 1)) begin
                  b_in      = '0;
                  glyph_end = 1'b1;
               end else begin
                  b_in = 8'(b_ff + 8'd1);
               end
            end
            if (glyph_end) begin
               if (mode_ff == mfde_pkg::MODE_CHAR || dig_ff == 3'd0) begin
                  done_in = 1'b1;
               end else begin
                  dig_in = 3'(dig_ff - 3'd1);
                  xb_in  = 8'(xb_ff + 8'(mfde_pkg::DIGIT_STEP));
               end
            end
         end
         default: done_in = 1'b1;
      endcase
   end

   // Double dabble correction and leading digit search.
   always_comb begin
      dig_top = '0;
      for (int i = 0; i < mfde_pkg::NUM_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? 4'(bcd_ff[i*4 +: 4] + 4'd3)
                                                        : bcd_ff[i*4 +: 4];
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            dig_top = 3'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mfde_pkg::mode_type'(req_mode);
         x_ff     <= req_x_pos;
         y_ff     <= req_y_pos;
         w_ff     <= req_rect_width;
         h_ff     <= req_rect_height;
         code_ff  <= req_char_code;
         on_ff    <= req_pixel_on;
         ridx_ff  <= AW'(req_read_index);
         rd_ok_ff <= (int'(req_read_index) < mfde_pkg::STORE_SIZE);
         xb_ff    <= req_x_pos;
         a_ff     <= '0;
         b_ff     <= '0;
         seg_ff   <= '0;
         dig_ff   <= '0;
         done_ff  <= 1'b0;
         bcd_ff   <= '0;
         bin_ff   <= req_number_value;
      end else begin
         if (cmd.bcd_step) begin
            {bcd_ff, bin_ff} <= {bcd_adj[18:0], bin_ff, 1'b0};
         end
         if (cmd.num_start) begin
            dig_ff <= dig_top;
         end
         if (cmd.advance) begin
            a_ff    <= a_in;
            b_ff    <= b_in;
            seg_ff  <= seg_in;
            dig_ff  <= dig_in;
            xb_ff   <= xb_in;
            done_ff <= done_in;
         end
      end
      if (cmd.scan_rd) begin
         hit_addr_ff <= pix_addr;
         hit_mask_ff <= 8'(8'd1 << row[2:0]);
         hit_on_ff   <= val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_cnt_ff   <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            bcd_cnt_ff <= '0;
         end else if (cmd.bcd_step) begin
            bcd_cnt_ff <= 4'(bcd_cnt_ff + 4'd1);
         end
         if (cmd.clear_step) begin
            clr_ff <= status.clear_last ? '0 : AW'(clr_ff + 1'b1);
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_data_ff <= (mode_ff == mfde_pkg::MODE_READ && rd_ok_ff) ? rd_data_ff : 8'd0;
      end
   end

   // Frame store: one write port and one registered read port.
   assign wr_en   = cmd.clear_step || cmd.plot_write;
   assign wr_addr = cmd.clear_step ? clr_ff : hit_addr_ff;
   assign wr_data = cmd.clear_step ? 8'd0
                  : (hit_on_ff ? (rd_data_ff | hit_mask_ff) : (rd_data_ff & ~hit_mask_ff));
   assign rd_en   = cmd.scan_rd || cmd.read_issue;
   assign rd_addr = cmd.read_issue ? ridx_ff : pix_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.plot_write |-> $past(cmd.scan_rd))
      else $error("plot write without a preceding read");
   a_clear_counter_idle: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear_step |=> $stable(clr_ff))
      else $error("clear counter moved outside a sweep");
   a_no_write_and_read: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("frame store read and written in one cycle");

endmodule

/* rtl/core/mono_framebuffer_draw_engine.sv */
// Top level of the monochrome framebuffer draw engine.
// Joins mfde_ctrl and mfde_datapath; depends on mfde_pkg.
//
// The engine takes one command at a time and returns one response per command. After reset
// it sweeps the 512-byte frame store to zero, one byte a cycle, and takes no command until
// the sweep ends; a clear command takes the same sweep. Drawing walks the pixel positions
// of the command one per cycle, but each visible pixel holds the walk for a read-modify-write
// of the frame store, read first and then written. Around the walk come the accept, a final
// walk check and the response; a number first converts its value to decimal, and a read
// issues the frame store read before the response. The response sits in an output register,
// and a new command is taken once the previous response has been loaded there.
module mono_framebuffer_draw_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [7:0]  req_rect_width,
   input  logic [7:0]  req_rect_height,
   input  logic [7:0]  req_char_code,
   input  logic [15:0] req_number_value,
   input  logic        req_pixel_on,
   input  logic [8:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data
);

   mfde_pkg::cmd_type    cmd;
   mfde_pkg::status_type status;

   mfde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mfde_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_char_code    (req_char_code),
      .req_number_value (req_number_value),
      .req_pixel_on     (req_pixel_on),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data)
   );

endmodule
